### design/rng_repetition_and_proportion_test_defines.svh
// Assertion macros used by the rrpt core design file.
`ifndef RNG_REPETITION_AND_PROPORTION_TEST_DEFINES_SVH
`define RNG_REPETITION_AND_PROPORTION_TEST_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define RRPT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrpt assertion failed");

// Next-cycle implication, disabled while reset is held.
`define RRPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrpt assertion failed");

`endif

### design/rrpt_pkg.sv
package rrpt_pkg;

  localparam int SYMBOL_BITS_DEF = 8;

  localparam int OP_W       = 2;
  localparam int SAMPLE_W   = 8;
  localparam int RCT_W      = 6;
  localparam int APT_CUT_W  = 10;
  localparam int APT_WIN_W  = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Register reset values
  localparam logic [RCT_W-1:0]     RCT_CUTOFF_RST = 6'd5;
  localparam logic [APT_CUT_W-1:0] APT_CUTOFF_RST = 10'd16;
  localparam logic [APT_WIN_W-1:0] APT_WINDOW_RST = 11'd512;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RCT_CUTOFF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_APT_CUTOFF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_APT_WINDOW = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE = 2'd0,
    OP_FINISH = 2'd1,
    OP_START  = 2'd2
  } op_t;

  typedef struct packed {
    logic [RCT_W-1:0]     rct_cutoff;
    logic [APT_CUT_W-1:0] apt_cutoff;
    logic [APT_WIN_W-1:0] apt_window;
  } cfg_t;

  typedef struct packed {
    logic healthy;
    logic verdict;
  } result_t;

endpackage

### design/rrpt_if.sv
interface rrpt_in_if import rrpt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output operation, output sample, input ready);
  modport sink (input valid, input operation, input sample, output ready);
endinterface

interface rrpt_out_if ();
  logic valid;
  logic ready;
  logic healthy;
  logic verdict;

  modport source (output valid, output healthy, output verdict, input ready);
  modport sink (input valid, input healthy, input verdict, output ready);
endinterface

interface rrpt_cfg_if import rrpt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### design/rng_repetition_and_proportion_test.sv
// Data path: an accepted item waits in the input register, and its result waits
//   in the result register until the sink takes the transfer.
// Throughput: one item per cycle unless the result sink stalls; the per-sample
//   compare-and-count state update is one registered step, so back-to-back samples flow.
// Reset (rst_n, synchronous, active low): monitor armed and empty, registers
//   back to rct_cutoff 5, apt_cutoff 16, apt_window 512, both stages empty.
module rng_repetition_and_proportion_test import rrpt_pkg::*; #(
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  rrpt_in_if.sink      in_ch,
  rrpt_out_if.source   out_ch,
  rrpt_cfg_if.sink     cfg_ch
);

  // Input register: holds one accepted item until the core consumes it.
  logic                in_vld_r, in_vld_nxt;
  logic [OP_W-1:0]     in_op_r;
  logic [SAMPLE_W-1:0] in_sample_r;

  // Result register: holds one result until the sink takes the transfer.
  logic    out_vld_r, out_vld_nxt;
  result_t out_res_r;

  logic    out_free;
  logic    core_fire;
  logic    in_take;
  cfg_t    cfg;
  result_t core_res;

  // The result slot frees up when empty or when its transfer completes this cycle.
  assign out_free  = !out_vld_r || out_ch.ready;
  // Commit the held item to the monitor state whenever its result has a place to go.
  assign core_fire = in_vld_r && out_free;
  // Accept a new item when the input register is empty or drains this cycle.
  assign in_ch.ready = !in_vld_r || out_free;
  assign in_take     = in_ch.valid && in_ch.ready;

  assign in_vld_nxt  = in_take || (in_vld_r && !core_fire);
  assign out_vld_nxt = core_fire || (out_vld_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers: load on transfer, otherwise hold.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_op_r     <= in_ch.operation;
      in_sample_r <= in_ch.sample;
    end
    if (core_fire) begin
      out_res_r <= core_res;
    end
  end

  rrpt_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // Monitor state and the two health tests.
  rrpt_core #(
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .fire   (core_fire),
    .op     (op_t'(in_op_r)),
    .sample (in_sample_r),
    .res    (core_res)
  );

  assign out_ch.valid   = out_vld_r;
  assign out_ch.healthy = out_res_r.healthy;
  assign out_ch.verdict = out_res_r.verdict;

endmodule

### design/rrpt_cfg.sv
module rrpt_cfg import rrpt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  rrpt_cfg_if.sink    cfg_ch,
  output cfg_t        cfg
);

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_RCT_CUTOFF: cfg_nxt.rct_cutoff = cfg_ch.data[RCT_W-1:0];
        REG_APT_CUTOFF: cfg_nxt.apt_cutoff = cfg_ch.data[APT_CUT_W-1:0];
        REG_APT_WINDOW: cfg_nxt.apt_window = cfg_ch.data[APT_WIN_W-1:0];
        default: cfg_nxt = cfg_r; // drop writes to unknown indexes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rct_cutoff <= RCT_CUTOFF_RST;
      cfg_r.apt_cutoff <= APT_CUTOFF_RST;
      cfg_r.apt_window <= APT_WINDOW_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### design/rrpt_core.sv
`include "rng_repetition_and_proportion_test_defines.svh"

module rrpt_core import rrpt_pkg::*; #(
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                fire,
  input  op_t                 op,
  input  logic [SAMPLE_W-1:0] sample,
  output result_t             res
);

  localparam logic [RCT_W-1:0]     RUN_MAX   = {RCT_W{1'b1}};
  localparam logic [APT_CUT_W-1:0] MATCH_MAX = {APT_CUT_W{1'b1}};
  localparam logic [APT_WIN_W-1:0] POS_MAX   = {APT_WIN_W{1'b1}};

  logic                   healthy_r, healthy_nxt;
  logic                   seen_r, seen_nxt;
  logic                   run_started_r, run_started_nxt;
  logic [SYMBOL_BITS-1:0] run_symbol_r, run_symbol_nxt;
  logic [RCT_W-1:0]       run_length_r, run_length_nxt;
  logic                   win_started_r, win_started_nxt;
  logic [SYMBOL_BITS-1:0] win_ref_r, win_ref_nxt;
  logic [APT_CUT_W-1:0]   match_r, match_nxt;
  logic [APT_WIN_W-1:0]   pos_r, pos_nxt;
  logic                   verdict;

  logic [SYMBOL_BITS-1:0] sym;
  logic [RCT_W-1:0]       run_inc;
  logic [APT_CUT_W-1:0]   match_inc;
  logic [APT_WIN_W-1:0]   pos_inc;

  assign sym       = SYMBOL_BITS'(sample);
  assign run_inc   = (run_length_r < RUN_MAX) ? run_length_r + 1'b1 : run_length_r;
  assign match_inc = (match_r < MATCH_MAX) ? match_r + 1'b1 : match_r;
  assign pos_inc   = (pos_r < POS_MAX) ? pos_r + 1'b1 : pos_r;

  always_comb begin
    healthy_nxt     = healthy_r;
    seen_nxt        = seen_r;
    run_started_nxt = run_started_r;
    run_symbol_nxt  = run_symbol_r;
    run_length_nxt  = run_length_r;
    win_started_nxt = win_started_r;
    win_ref_nxt     = win_ref_r;
    match_nxt       = match_r;
    pos_nxt         = pos_r;
    verdict         = 1'b0;
    if (fire) begin
      unique case (op)
        OP_SAMPLE: begin
          if (healthy_r) begin
            seen_nxt = 1'b1;
            // repetition count: run carries across windows
            if (!run_started_r || sym != run_symbol_r) begin
              run_started_nxt = 1'b1;
              run_symbol_nxt  = sym;
              run_length_nxt  = RCT_W'(1);
            end else begin
              run_length_nxt = run_inc;
            end
            if (run_started_r && sym == run_symbol_r && run_inc >= cfg.rct_cutoff) begin
              healthy_nxt = 1'b0;
            end else if (!win_started_r) begin
              // first sample of a window becomes the reference
              win_started_nxt = 1'b1;
              win_ref_nxt     = sym;
              match_nxt       = '0;
              pos_nxt         = APT_WIN_W'(1);
            end else if (sym == win_ref_r && match_inc >= cfg.apt_cutoff) begin
              match_nxt   = match_inc;
              healthy_nxt = 1'b0;
            end else begin
              if (sym == win_ref_r) begin
                match_nxt = match_inc;
              end
              pos_nxt = pos_inc;
              if (pos_inc >= cfg.apt_window) begin
                win_started_nxt = 1'b0;
              end
            end
          end
        end
        OP_FINISH, OP_START: begin
          verdict         = (op == OP_FINISH) && healthy_r && seen_r;
          healthy_nxt     = (op == OP_START);
          seen_nxt        = 1'b0;
          run_started_nxt = 1'b0;
          run_symbol_nxt  = '0;
          run_length_nxt  = '0;
          win_started_nxt = 1'b0;
          win_ref_nxt     = '0;
          match_nxt       = '0;
          pos_nxt         = '0;
        end
        default: ; // unused code: hold all state
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      healthy_r     <= 1'b1;
      seen_r        <= 1'b0;
      run_started_r <= 1'b0;
      run_symbol_r  <= '0;
      run_length_r  <= '0;
      win_started_r <= 1'b0;
      win_ref_r     <= '0;
      match_r       <= '0;
      pos_r         <= '0;
    end else begin
      healthy_r     <= healthy_nxt;
      seen_r        <= seen_nxt;
      run_started_r <= run_started_nxt;
      run_symbol_r  <= run_symbol_nxt;
      run_length_r  <= run_length_nxt;
      win_started_r <= win_started_nxt;
      win_ref_r     <= win_ref_nxt;
      match_r       <= match_nxt;
      pos_r         <= pos_nxt;
    end
  end

  assign res.healthy = healthy_nxt;
  assign res.verdict = verdict;

  `RRPT_ASSERT_NEXT(a_start_rearms, clk, rst_n, fire && op == OP_START, healthy_r && !seen_r)
  `RRPT_ASSERT_NEXT(a_finish_idles, clk, rst_n, fire && op == OP_FINISH, !healthy_r && !seen_r)
  `RRPT_ASSERT_NEXT(a_fail_latches, clk, rst_n, !healthy_r && !(fire && op == OP_START), !healthy_r)
  `RRPT_ASSERT_NOW(a_verdict_clears, clk, rst_n, verdict, !res.healthy && seen_r)
  `RRPT_ASSERT_NOW(a_run_idle_zero, clk, rst_n, !run_started_r, run_length_r == '0)

endmodule

### dv/rng_repetition_and_proportion_test_test.sv
module rng_repetition_and_proportion_test_test import rrpt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Operation code and register index that the block must ignore.
  localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Saturation points of the monitor's counters.
  localparam logic [RCT_W-1:0]     RUN_CAP   = 6'd63;
  localparam logic [APT_CUT_W-1:0] MATCH_CAP = 10'd1023;
  localparam logic [APT_WIN_W-1:0] POS_CAP   = 11'd2047;

  // Cycles without any transfer on any channel before the run is declared hung.
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  // Mismatch lines printed before the rest are only counted.
  localparam int unsigned PRINT_CAP = 60;

  typedef struct {
    result_t     res;
    int unsigned item;
  } health_due_t;

  logic clk;
  logic rst_n;

  rrpt_in_if  in_ch ();
  rrpt_out_if out_ch ();
  rrpt_cfg_if cfg_ch ();

  rng_repetition_and_proportion_test dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Expected health/verdict pairs, oldest first, one per accepted input transfer.
  health_due_t pending_health[$];

  int unsigned send_idle_pct = 35;
  int unsigned recv_idle_pct = 88;
  int unsigned mismatches    = 0;
  int unsigned items_sent    = 0;
  int unsigned stall_cycles  = 0;

  // Register copies, tracked at each accepted configuration transfer.
  logic [RCT_W-1:0]     rct_lim;
  logic [APT_CUT_W-1:0] apt_lim;
  logic [APT_WIN_W-1:0] win_len;

  // Monitor state: latch, run tracker (repetition test), window tracker (proportion test).
  logic                 mon_healthy;
  logic                 mon_seen;
  logic                 mon_run_on;
  logic [SAMPLE_W-1:0]  mon_run_sym;
  logic [RCT_W-1:0]     mon_run_len;
  logic                 mon_win_on;
  logic [SAMPLE_W-1:0]  mon_win_ref;
  logic [APT_CUT_W-1:0] mon_matches;
  logic [APT_WIN_W-1:0] mon_win_pos;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Monitor prediction
  // ---------------------------------------------------------------------------

  // Start re-arms (armed = 1); finish leaves the monitor failed and idle.
  function automatic void clear_monitor(logic armed);
    mon_healthy = armed;
    mon_seen    = 1'b0;
    mon_run_on  = 1'b0;
    mon_run_sym = '0;
    mon_run_len = '0;
    mon_win_on  = 1'b0;
    mon_win_ref = '0;
    mon_matches = '0;
    mon_win_pos = '0;
  endfunction

  // Score one symbol while healthy. A trip on either test latches the failure and
  // stops the rest of the update for this symbol.
  function automatic void score_sample(logic [SAMPLE_W-1:0] s);
    mon_seen = 1'b1;

    // Repetition test: the first symbol of a run is never compared with the cutoff.
    if (!mon_run_on) begin
      mon_run_on  = 1'b1;
      mon_run_sym = s;
      mon_run_len = 1;
    end else if (s == mon_run_sym) begin
      if (mon_run_len < RUN_CAP) mon_run_len++;
      if (mon_run_len >= rct_lim) begin
        mon_healthy = 1'b0;
        return;
      end
    end else begin
      mon_run_sym = s;
      mon_run_len = 1;
    end

    // Proportion test: the first symbol of a window only becomes the reference.
    if (!mon_win_on) begin
      mon_win_on  = 1'b1;
      mon_win_ref = s;
      mon_matches = '0;
      mon_win_pos = 1;
      return;
    end

    if (s == mon_win_ref) begin
      if (mon_matches < MATCH_CAP) mon_matches++;
      if (mon_matches >= apt_lim) begin
        mon_healthy = 1'b0;
        return;
      end
    end

    // Close the window once it holds apt_window symbols, reference included.
    if (mon_win_pos < POS_CAP) mon_win_pos++;
    if (mon_win_pos >= win_len) mon_win_on = 1'b0;
  endfunction

  // Advance the monitor by one input transfer and return the result it produces.
  // Samples while failed and the unused code leave the monitor as it is.
  function automatic result_t predict_health(input logic [OP_W-1:0] op,
                                             input logic [SAMPLE_W-1:0] s);
    result_t r;
    r.verdict = 1'b0;
    case (op)
      OP_SAMPLE: begin
        if (mon_healthy) score_sample(s);
      end
      OP_FINISH: begin
        r.verdict = mon_healthy & mon_seen;
        clear_monitor(1'b0);
      end
      OP_START: begin
        clear_monitor(1'b1);
      end
      default: ;
    endcase
    r.healthy = mon_healthy;
    return r;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_RCT_CUTOFF: rct_lim = data[RCT_W-1:0];
      REG_APT_CUTOFF: apt_lim = data[APT_CUT_W-1:0];
      REG_APT_WINDOW: win_len = data[APT_WIN_W-1:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report(string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // Result side: check each result transfer against the oldest expectation, then
  // pick the next cycle's ready. Sampling right after the edge sees pre-edge values.
  initial begin
    health_due_t due;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_health.size() == 0) begin
          report("result transfer with nothing expected");
        end else begin
          due = pending_health.pop_front();
          if (out_ch.healthy !== due.res.healthy)
            report($sformatf("item %0d healthy: expected %b, got %b",
                             due.item, due.res.healthy, out_ch.healthy));
          if (out_ch.verdict !== due.res.verdict)
            report($sformatf("item %0d verdict: expected %b, got %b",
                             due.item, due.res.verdict, out_ch.verdict));
        end
      end
      out_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // Watchdog: restart the count on any transfer, give up after a long silence.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("no transfer for %0d cycles", stall_cycles);
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Send one item: idle at random first, then hold valid until the transfer.
  // Valid stays high afterwards so back-to-back items never drop it in between.
  task automatic send_item(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] s);
    result_t r;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.sample    <= s;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    r = predict_health(op, s);
    items_sent++;
    pending_health.push_back('{res: r, item: items_sent});
  endtask

  // Drop valid and wait until every expected result has been transferred.
  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_health.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    apply_register(idx, data);
  endtask

  // Registers change only with the monitor idle: drain first, then write all three.
  task automatic load_limits(logic [CFG_DATA_W-1:0] rct, logic [CFG_DATA_W-1:0] apt,
                             logic [CFG_DATA_W-1:0] win);
    hold_until_drained();
    write_reg(REG_RCT_CUTOFF, rct);
    write_reg(REG_APT_CUTOFF, apt);
    write_reg(REG_APT_WINDOW, win);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly small limits so both tests trip often; extremes now and then. Unused
  // upper data bits are randomized for the two narrower registers.
  task automatic load_random_limits();
    logic [CFG_DATA_W-1:0] rct, apt, win;
    case ($urandom_range(7, 0))
      0:       rct = 0;
      1:       rct = 1;
      2:       rct = 63;
      default: rct = $urandom_range(8, 2);
    endcase
    rct[CFG_DATA_W-1:RCT_W] = $urandom;
    case ($urandom_range(7, 0))
      0:       apt = 0;
      1:       apt = 1;
      2:       apt = 1023;
      default: apt = $urandom_range(12, 1);
    endcase
    apt[CFG_DATA_W-1] = $urandom;
    case ($urandom_range(9, 0))
      0:       win = 0;
      1:       win = 1;
      2:       win = 2;
      3:       win = 1024;
      4:       win = 2047;
      default: win = $urandom_range(24, 2);
    endcase
    load_limits(rct, apt, win);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset limits (cutoffs 5 and 16, window 512), no register writes yet.
  task automatic test_reset_limits();
    // Finish with nothing seen: verdict low, monitor left failed.
    send_item(OP_FINISH, 8'h00);
    // Both ignored while failed.
    send_item(OP_SAMPLE, 8'hFF);
    send_item(OP_UNUSED, 8'h00);
    // Re-arm, score the extreme symbols, finish healthy.
    send_item(OP_START, 8'hFF);
    send_item(OP_SAMPLE, 8'h00);
    send_item(OP_SAMPLE, 8'hFF);
    send_item(OP_FINISH, 8'hFF);
    // Five identical symbols trip the repetition test; the verdict is then low.
    send_item(OP_START, 8'h00);
    repeat (5) send_item(OP_SAMPLE, 8'hA5);
    send_item(OP_FINISH, 8'h5A);
  endtask

  // Cutoffs 2 and 1 with a three-symbol window.
  task automatic test_tight_cutoffs();
    load_limits(2, 1, 3);
    // Write the unused index; the limits must stay as they are.
    write_reg(REG_UNUSED, '1);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    // A reference match trips the proportion test.
    send_item(OP_START, 8'h00);
    send_item(OP_SAMPLE, 8'h11);
    send_item(OP_SAMPLE, 8'h22);
    send_item(OP_SAMPLE, 8'h11);
    // Window closes after 33; 11 opens a new one; the run of 22 trips repetition.
    send_item(OP_START, 8'h00);
    send_item(OP_SAMPLE, 8'h11);
    send_item(OP_SAMPLE, 8'h22);
    send_item(OP_SAMPLE, 8'h33);
    send_item(OP_SAMPLE, 8'h11);
    send_item(OP_SAMPLE, 8'h22);
    send_item(OP_SAMPLE, 8'h22);
  endtask

  // Zero cutoffs: the first symbol of a run and of a window passes unchecked.
  task automatic test_first_sample_unchecked();
    load_limits(0, 0, 1);
    send_item(OP_START, 8'h00);
    send_item(OP_SAMPLE, 8'h5A);
    send_item(OP_SAMPLE, 8'h3C);
    send_item(OP_FINISH, 8'h00);
  endtask

  // Sessions of start, samples, finish with random content, plus some noise.
  // quota counts input transfers, ignored ones included.
  task automatic run_random_traffic(int unsigned quota);
    int unsigned         goal, len, mode;
    logic [SAMPLE_W-1:0] s, base;
    goal = items_sent + quota;
    while (items_sent < goal) begin
      if ($urandom_range(4, 0) == 0) load_random_limits();
      if ($urandom_range(99, 0) < 15) begin
        // Noise: any operation code, unused one included.
        repeat ($urandom_range(4, 1)) send_item($urandom_range(3, 0), $urandom);
      end else begin
        send_item(OP_START, $urandom);
        len  = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 0) : $urandom_range(20, 1);
        mode = $urandom_range(2, 0);
        base = $urandom;
        s    = $urandom;
        repeat (len) begin
          // Full-range symbols, a narrow alphabet (proportion hits), or long runs.
          case (mode)
            0:       s = $urandom;
            1:       s = base + $urandom_range(2, 0);
            default: if ($urandom_range(9, 0) >= 6) s = $urandom;
          endcase
          send_item(OP_SAMPLE, s);
          if ($urandom_range(99, 0) == 0) hold_until_drained();
        end
        if ($urandom_range(9, 0) != 0) send_item(OP_FINISH, $urandom);
      end
    end
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 35;
    recv_idle_pct = 88;
    run_random_traffic(270);
    send_idle_pct = 88;
    recv_idle_pct = 35;
    run_random_traffic(270);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_traffic(270);
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_SAMPLE;
    in_ch.sample    <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= REG_RCT_CUTOFF;
    cfg_ch.data     <= '0;
    rct_lim = RCT_CUTOFF_RST;
    apt_lim = APT_CUTOFF_RST;
    win_len = APT_WINDOW_RST;
    clear_monitor(1'b1);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_limits();
    test_tight_cutoffs();
    test_first_sample_unchecked();
    test_random_traffic();

    // Let the pipeline settle so any stray result still gets flagged.
    hold_until_drained();
    repeat (6) @(posedge clk);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
